// File: src/dbrr_pkg.sv
// Shared constants, operation codes and command types of the round robin board sender.
`default_nettype none
package dbrr_pkg;

    localparam int BOARDS   = 8;
    localparam int DIGITS   = 8;
    localparam int BOARD_W  = (BOARDS > 1) ? $clog2(BOARDS) : 1;
    localparam int WORD_W   = 8 * DIGITS;

    localparam int OP_W     = 2;
    localparam int IN_BRD_W = 3;
    localparam int DIG_W    = 64;
    localparam int MASK_W   = 8;

    localparam logic [MASK_W-1:0] TOP_MASK_BIT = 8'h80;

    typedef enum logic [OP_W-1:0] {
        OP_PAINT   = 2'd0,
        OP_SEND    = 2'd1,
        OP_REFRESH = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef struct packed {
        logic paint;
        logic send;
        logic refresh;
    } t_cmd;

endpackage
`default_nettype wire

// File: src/dbrr_if.sv
// Valid/ready channel interfaces for request items and result items.
`default_nettype none
interface dbrr_req_if import dbrr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [IN_BRD_W-1:0] board;
    logic [DIG_W-1:0]    digits;
    logic [MASK_W-1:0]   mask;
    logic                accepted;

    modport source (output valid, op, board, digits, mask, accepted, input ready);
    modport sink   (input valid, op, board, digits, mask, accepted, output ready);
endinterface

interface dbrr_rsp_if import dbrr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                found;
    logic [IN_BRD_W-1:0] sent_board;
    logic [DIG_W-1:0]    sent_digits;

    modport source (output valid, found, sent_board, sent_digits, input ready);
    modport sink   (input valid, found, sent_board, sent_digits, output ready);
endinterface
`default_nettype wire

// File: src/dbrr_ctrl.sv
// Controller state machine: request acceptance, commands and the result slot.
`default_nettype none
module dbrr_ctrl import dbrr_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic [OP_W-1:0] i_op,
    input  wire logic            i_out_ready,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output t_cmd                 o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_HOLD = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    always_comb begin
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_HOLD:  o_in_ready = i_out_ready;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_HOLD);

    always_comb begin
        o_cmd = '0;
        if (w_accept) begin
            unique case (t_op'(i_op))
                OP_PAINT:   o_cmd.paint   = 1'b1;
                OP_SEND:    o_cmd.send    = 1'b1;
                OP_REFRESH: o_cmd.refresh = 1'b1;
                default:    o_cmd = '0;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.send) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (o_cmd.send)       n_state = S_HOLD;
                else if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    a_send_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.send |=> o_out_valid)
        else $error("send request did not produce a result");

    a_block_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("request taken while result slot is full");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.paint, o_cmd.send, o_cmd.refresh}))
        else $error("more than one command issued");

endmodule
`default_nettype wire

// File: src/dbrr_dpath.sv
// Datapath: digit store, changed flags, round robin search and result registers.
`default_nettype none
module dbrr_dpath import dbrr_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    input  wire logic [IN_BRD_W-1:0] i_board,
    input  wire logic [DIG_W-1:0]    i_digits,
    input  wire logic [MASK_W-1:0]   i_mask,
    input  wire logic                i_accepted,
    output logic                     o_found,
    output logic [IN_BRD_W-1:0]      o_sent_board,
    output logic [DIG_W-1:0]         o_sent_digits
);

    logic [7:0]         r_mem [BOARDS][DIGITS];
    logic [BOARDS-1:0]  r_row_valid;
    logic [BOARDS-1:0]  r_flags;
    logic [BOARD_W-1:0] r_last;
    logic               r_found;
    logic [BOARD_W-1:0] r_board;
    logic [WORD_W-1:0]  r_rd;

    logic               w_in_range;
    logic [BOARD_W-1:0] w_paint_idx;
    logic [DIGITS-1:0]  w_sel;
    logic               w_hit;
    logic [BOARD_W-1:0] w_idx;
    logic [BOARD_W:0]   w_sum;

    assign w_in_range  = (32'(i_board) < BOARDS);
    assign w_paint_idx = BOARD_W'(i_board);

    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            w_sel[d] = |(i_mask & (TOP_MASK_BIT >> d));
        end
    end

    always_comb begin
        w_hit = 1'b0;
        w_idx = '0;
        w_sum = '0;
        for (int k = BOARDS - 1; k >= 0; k--) begin
            w_sum = {1'b0, r_last} + (BOARD_W + 1)'(k + 1);
            if (32'(w_sum) >= BOARDS) w_sum = w_sum - (BOARD_W + 1)'(BOARDS);
            if (r_flags[BOARD_W'(w_sum)]) begin
                w_hit = 1'b1;
                w_idx = BOARD_W'(w_sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.paint && w_in_range) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (w_sel[d] || !r_row_valid[w_paint_idx]) begin
                    r_mem[w_paint_idx][d] <= w_sel[d] ? i_digits[8*d +: 8] : 8'h00;
                end
            end
        end
        if (i_cmd.send) begin
            for (int d = 0; d < DIGITS; d++) begin
                r_rd[8*d +: 8] <= (w_hit && r_row_valid[w_idx]) ? r_mem[w_idx][d] : 8'h00;
            end
            r_board <= w_hit ? w_idx : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_flags     <= '0;
            r_last      <= '0;
            r_found     <= 1'b0;
        end else begin
            if (i_cmd.paint && w_in_range) begin
                r_row_valid[w_paint_idx] <= 1'b1;
                r_flags[w_paint_idx]     <= 1'b1;
            end
            if (i_cmd.refresh) begin
                r_flags <= '1;
            end
            if (i_cmd.send) begin
                r_found <= w_hit;
                if (w_hit) begin
                    r_last <= w_idx;
                    if (i_accepted) r_flags[w_idx] <= 1'b0;
                end
            end
        end
    end

    assign o_found       = r_found;
    assign o_sent_board  = IN_BRD_W'(r_board);
    assign o_sent_digits = DIG_W'(r_rd);

    a_refresh_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.refresh |=> (&r_flags))
        else $error("refresh left a board unmarked");

    a_clear_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.send && w_hit && i_accepted) |=> !r_flags[$past(w_idx)])
        else $error("accepted board kept its changed flag");

    a_miss_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.send && !w_hit) |=> ($stable(r_last) && !r_found))
        else $error("empty search changed the served index");

endmodule
`default_nettype wire

// File: src/dirty_board_round_robin_sender.sv
// Top level of the round robin sender of changed display boards.
//
//  Channel  Dir  Handshake    Payload
//  i_req    in   valid/ready  op, board, digits, mask, accepted
//  o_rsp    out  valid/ready  found, sent_board, sent_digits (one per send request)
//
// A request is accepted in a cycle with i_req.ready high; paint and refresh requests finish at that edge.
// A send request searches the changed flags and reads one store row at its acceptance
// edge, and its result is presented from the next cycle on.
// While a result waits, a new request is taken only in a cycle in which o_rsp is taken.
// Synchronous active-low reset clears the flags, the served index and the row valid bits.
`default_nettype none
module dirty_board_round_robin_sender import dbrr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dbrr_req_if.sink    i_req,
    dbrr_rsp_if.source  o_rsp
);

    t_cmd w_cmd;

    dbrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_op        (i_req.op),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (w_cmd)
    );

    dbrr_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_board       (i_req.board),
        .i_digits      (i_req.digits),
        .i_mask        (i_req.mask),
        .i_accepted    (i_req.accepted),
        .o_found       (o_rsp.found),
        .o_sent_board  (o_rsp.sent_board),
        .o_sent_digits (o_rsp.sent_digits)
    );

endmodule
`default_nettype wire
